### src/hthd_pkg.sv
// Shared constants and controller/datapath interface types for the heap tree Huffman decoder.
`timescale 1ns / 1ps

package hthd_pkg;

   localparam int TREE_ENTRIES_DEF = 4096;
   localparam int SIZE_W           = 13;
   localparam int ADDR_W           = 12;
   localparam int SYM_W            = 8;
   localparam int CODE_W           = 8;
   localparam int MSB_INDEX        = 7;
   localparam int SIZE_RESET       = 4096;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic start;        // latch a code byte
      logic write;        // write one tree entry
      logic rd_sym;       // fetch the entry of the current position
      logic rd_kids;      // fetch the child pair of the current position
      logic capture_sym;  // latch the fetched entry as the current symbol
      logic step;         // walk one code bit
      logic flush;        // release the held symbol as the last of the byte
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic leaf;
      logic pend_valid;
      logic out_free;
   } status_type;

endpackage

### src/heap_tree_huffman_decoder_top.sv
// Top level of the heap tree Huffman decoder: stream ports, controller and datapath.
`timescale 1ns / 1ps

// Decodes Huffman code bytes against a code tree stored as a heap-indexed array
// (root at position 1, children of p at 2p and 2p+1, position p in entry p-1).
// A request with tuser high writes one tree entry and yields no result. A
// request with tuser low walks the eight bits of its code byte, MSB first, and
// emits a symbol each time the walk stands on a leaf before a bit; tlast marks
// the last symbol of that byte. A code byte occupies the block through accept,
// entry fetch, child fetch, eight bit steps and hand off of the held symbol, plus
// any stalls of the result side; the walk is bit-serial, one child-pair read of
// the even/odd banked tree memory per bit. The tree is not cleared after reset:
// every entry below the tree size must be loaded before decoding. The size
// register may be written only while the block is idle.
module heap_tree_huffman_decoder_top
   import hthd_pkg::*;
#(
   parameter int TREE_ENTRIES = TREE_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // entry_address[11:0], entry_symbol[19:12],
                                          // code_byte[27:20], zero[31:28]
   input  logic              req_tuser,   // mode
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // symbol[7:0]
   output logic              rsp_tlast,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SIZE_W-1:0] csr_data     // tree_size
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   hthd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hthd_datapath #(
      .TREE_ENTRIES (TREE_ENTRIES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .entry_address (req_tdata[11:0]),
      .entry_symbol  (req_tdata[19:12]),
      .code_byte     (req_tdata[27:20]),
      .csr_write     (csr_valid && csr_ready),
      .csr_size      (csr_data),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_symbol    (rsp_tdata),
      .rsp_tlast     (rsp_tlast)
   );

endmodule

### src/hthd_ctrl.sv
// Sequencer for the heap tree Huffman decoder: accepts items and walks the code bits.
`timescale 1ns / 1ps

module hthd_ctrl
   import hthd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_mode,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SYM   = 3'd1;
   localparam logic [2:0] S_KIDS  = 3'd2;
   localparam logic [2:0] S_STEP  = 3'd3;
   localparam logic [2:0] S_FLUSH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       step_ok;

   assign step_ok = !(status.leaf && status.pend_valid && !status.out_free);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_mode) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = S_SYM;
               end
            end
         end
         S_SYM: begin
            cmd.rd_sym = 1'b1;
            state_in   = S_KIDS;
         end
         S_KIDS: begin
            cmd.rd_kids     = 1'b1;
            cmd.capture_sym = 1'b1;
            cnt_in          = '0;
            state_in        = S_STEP;
         end
         S_STEP: begin
            cmd.step = step_ok;
            if (step_ok) begin
               if (cnt_ff == 3'(MSB_INDEX)) begin
                  state_in = S_FLUSH;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
         end
         S_FLUSH: begin
            cmd.flush = status.out_free || !status.pend_valid;
            if (cmd.flush) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // a stalled bit step keeps its place
   a_step_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP && !cmd.step) |=> (state_ff == S_STEP && $stable(cnt_ff)))
      else $error("bit step lost while stalled");

   // exactly eight bit steps follow the child fetch
   a_eight_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP && cmd.step && cnt_ff != 3'(MSB_INDEX)) |=> state_ff == S_STEP)
      else $error("walk ended early");

   // input is taken only between transactions
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready == (state_ff == S_IDLE))
      else $error("input accepted during a walk");

endmodule

### src/hthd_datapath.sv
// Tree memory, position walk, held symbol and result register of the heap tree Huffman decoder.
`timescale 1ns / 1ps

module hthd_datapath
   import hthd_pkg::*;
#(
   parameter int TREE_ENTRIES = TREE_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [ADDR_W-1:0] entry_address,
   input  logic [SYM_W-1:0]  entry_symbol,
   input  logic [CODE_W-1:0] code_byte,
   input  logic              csr_write,
   input  logic [SIZE_W-1:0] csr_size,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [SYM_W-1:0]  rsp_symbol,
   output logic              rsp_tlast
);

   localparam int PW     = $clog2(TREE_ENTRIES + 2);
   localparam int LW     = PW + 1;
   localparam int CW     = (LW > SIZE_W + 1) ? LW : SIZE_W + 1;
   localparam int EVEN_D = (TREE_ENTRIES + 1) / 2;
   localparam int ODD_D  = TREE_ENTRIES / 2;
   localparam int BW     = $clog2(EVEN_D);
   localparam logic [CW-1:0] ENTRIES_C = CW'(TREE_ENTRIES);
   localparam logic [CW-1:0] EFF_RESET =
      (SIZE_RESET < TREE_ENTRIES) ? CW'(SIZE_RESET) : CW'(TREE_ENTRIES);

   // even entries in one bank, odd in the other: a child pair is one read of each
   logic [SYM_W-1:0]  even_mem [0:EVEN_D-1];
   logic [SYM_W-1:0]  odd_mem  [0:ODD_D-1];
   logic [SYM_W-1:0]  rd_even_ff, rd_odd_ff;
   logic [SYM_W-1:0]  shadow1_ff, shadow2_ff;

   logic [CW-1:0]     eff_ff;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic [CODE_W-1:0] code_ff;
   logic              pend_valid_ff;
   logic [SYM_W-1:0]  pend_sym_ff;
   logic              rsp_valid_ff;
   logic [SYM_W-1:0]  rsp_sym_ff;
   logic              rsp_last_ff;

   logic [CW-1:0]     pos_ext, left_idx, right_idx, sym_idx, addr_ext;
   logic              left_ok, right_ok, sym_ok, leaf, code_bit, out_free;
   logic              wr_ok, push_step, push_flush, rd_en;
   logic [SYM_W-1:0]  l_ent, r_ent, sh1_ent, sh2_ent, sym_raw;
   logic [PW:0]       pos_desc;
   logic [PW-1:0]     kid_pos, kid_pos_m1, pos_m1, pos_half;
   logic [BW-1:0]     even_addr, odd_addr, wr_addr;

   // leaf test on the current position
   assign pos_ext   = CW'(pos_ff);
   assign left_idx  = (pos_ext << 1) - CW'(1);
   assign right_idx = pos_ext << 1;
   assign left_ok   = left_idx < eff_ff;
   assign right_ok  = right_idx < eff_ff;
   assign l_ent     = left_ok  ? rd_odd_ff  : '0;
   assign r_ent     = right_ok ? rd_even_ff : '0;
   assign leaf      = !left_ok || (l_ent == '0 && r_ent == '0);
   assign sh1_ent   = (CW'(1) < eff_ff) ? shadow1_ff : '0;
   assign sh2_ent   = (CW'(2) < eff_ff) ? shadow2_ff : '0;
   assign code_bit  = code_ff[MSB_INDEX];

   // next position: a leaf restarts at the root before taking the bit
   assign pos_desc = {pos_ff, code_bit};
   assign pos_in   = leaf ? (PW'(2) | PW'(code_bit)) : pos_desc[PW-1:0];
   assign sym_in   = leaf ? (code_bit ? sh2_ent : sh1_ent) : (code_bit ? r_ent : l_ent);

   // entry of the current position at the start of a byte
   assign sym_idx = pos_ext - CW'(1);
   assign sym_ok  = sym_idx < eff_ff;
   assign sym_raw = pos_ff[0] ? rd_even_ff : rd_odd_ff;

   // read addresses
   assign kid_pos    = cmd.step ? pos_in : pos_ff;
   assign kid_pos_m1 = kid_pos - PW'(1);
   assign pos_m1     = pos_ff - PW'(1);
   assign pos_half   = pos_m1 >> 1;
   assign even_addr  = cmd.rd_sym ? pos_half[BW-1:0] : kid_pos[BW-1:0];
   assign odd_addr   = cmd.rd_sym ? pos_half[BW-1:0] : kid_pos_m1[BW-1:0];
   assign rd_en      = cmd.rd_sym || cmd.rd_kids || cmd.step;

   assign addr_ext = CW'(entry_address);
   assign wr_addr  = addr_ext[BW:1];
   assign wr_ok    = cmd.write && (addr_ext < ENTRIES_C);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign push_step  = cmd.step && leaf && pend_valid_ff;
   assign push_flush = cmd.flush && pend_valid_ff;

   assign status.leaf       = leaf;
   assign status.pend_valid = pend_valid_ff;
   assign status.out_free   = out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_symbol = rsp_sym_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (wr_ok && !addr_ext[0]) begin
         even_mem[wr_addr] <= entry_symbol;
      end
      if (rd_en) begin
         rd_even_ff <= even_mem[even_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ok && addr_ext[0]) begin
         odd_mem[wr_addr] <= entry_symbol;
      end
      if (rd_en) begin
         rd_odd_ff <= odd_mem[odd_addr];
      end
   end

   // copies of the root's children, needed in the same cycle as a leaf
   always_ff @(posedge clock) begin
      if (wr_ok && addr_ext == CW'(1)) begin
         shadow1_ff <= entry_symbol;
      end
      if (wr_ok && addr_ext == CW'(2)) begin
         shadow2_ff <= entry_symbol;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         code_ff <= code_byte;
      end else if (cmd.step) begin
         code_ff <= {code_ff[MSB_INDEX-1:0], 1'b0};
      end
      if (cmd.capture_sym) begin
         sym_ff <= sym_ok ? sym_raw : '0;
      end else if (cmd.step) begin
         sym_ff <= sym_in;
      end
      if (cmd.step && leaf) begin
         pend_sym_ff <= sym_ff;
      end
      if (push_step || push_flush) begin
         rsp_sym_ff  <= pend_sym_ff;
         rsp_last_ff <= push_flush;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_ff        <= EFF_RESET;
         pos_ff        <= PW'(1);
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            eff_ff <= (CW'(csr_size) < ENTRIES_C) ? CW'(csr_size) : ENTRIES_C;
         end
         if (cmd.step) begin
            pos_ff <= pos_in;
         end
         if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end else if (cmd.step && leaf) begin
            pend_valid_ff <= 1'b1;
         end
         if (push_step || push_flush) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // the walk stays inside the root .. TREE_ENTRIES+1 range
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff != '0 && CW'(pos_ff) <= CW'(TREE_ENTRIES + 1))
      else $error("tree position out of range");

   // a result is never written over one that waits
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (push_step || push_flush) |-> out_free)
      else $error("result register overrun");

   // the held symbol leaves at the end of every byte
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> !pend_valid_ff)
      else $error("held symbol survived the end of the byte");

endmodule
